// ===== src/bsc_pkg.sv =====
package bsc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP_COEFFS       = 3'd0,
    REG_PRESS_COEFFS_LOW  = 3'd1,
    REG_PRESS_COEFFS_HIGH = 3'd2,
    REG_PRESS_HUM_COEFFS  = 3'd3,
    REG_HUM_COEFFS        = 3'd4,
    REG_HUMIDITY_ENABLE   = 3'd5
  } reg_idx_t;

  // Per-transaction fields that ride alongside the pressure divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        invalid;
  } side_t;

  localparam logic [32:0] FINE_OFFSET_P  = 33'd128000;
  localparam logic [31:0] FINE_OFFSET_H  = 32'd76800;
  localparam logic [63:0] P1_BIAS        = 64'h0000_8000_0000_0000;
  localparam logic [20:0] P_FULL_SCALE   = 21'd1048576;
  localparam logic signed [16:0] P_SCALE = 17'sd3125;
  localparam logic [31:0] H_ROUND_A      = 32'd16384;
  localparam logic [31:0] H_BIAS_B       = 32'd32768;
  localparam logic [31:0] H_BIAS_C       = 32'd2097152;
  localparam logic [31:0] H_ROUND_C      = 32'd8192;
  localparam logic [31:0] HUM_LIMIT      = 32'd419430400;
  localparam logic [16:0] HUM_MAX        = 17'd102400;

  // Low 32 bits of a 32 x 32 product (sign does not matter for the low half)
  function automatic logic [31:0] mul32lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  // Low 64 bits of a 64-bit word times a sign-extended 17-bit coefficient
  function automatic logic [63:0] mul64s17(input logic [63:0] a,
                                           input logic signed [16:0] b);
    logic signed [49:0] plo;
    logic signed [49:0] phi;
    plo = $signed({1'b0, a[31:0]}) * b;
    phi = $signed({1'b0, a[63:32]}) * b;
    return {{14{plo[49]}}, plo} + {phi[31:0], 32'b0};
  endfunction

endpackage

// ===== src/bsc_div.sv =====
module bsc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  logic [63:0]     num_mag,
  input  logic [30:0]     den_mag,
  input  logic            neg,
  input  bsc_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [63:0]     quot,
  output bsc_pkg::side_t  out_side
);
  import bsc_pkg::*;

  localparam int Steps = 64;

  logic [31:0] rem [Steps];
  logic [63:0] nq  [Steps];
  logic [30:0] dv  [Steps];
  logic        sg  [Steps];
  side_t       sd  [Steps];
  logic        vld [Steps];

  // One quotient bit per stage, restoring division
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [31:0] rem_in;
    logic [63:0] nq_in;
    logic [30:0] dv_in;
    logic        sg_in;
    side_t       sd_in;
    logic        vld_in;
    logic [31:0] shifted;
    logic [32:0] trial;

    if (i == 0) begin : g_head
      assign rem_in = '0;
      assign nq_in  = num_mag;
      assign dv_in  = den_mag;
      assign sg_in  = neg;
      assign sd_in  = in_side;
      assign vld_in = in_valid;
    end else begin : g_body
      assign rem_in = rem[i-1];
      assign nq_in  = nq[i-1];
      assign dv_in  = dv[i-1];
      assign sg_in  = sg[i-1];
      assign sd_in  = sd[i-1];
      assign vld_in = vld[i-1];
    end

    assign shifted = {rem_in[30:0], nq_in[63]};
    assign trial   = {1'b0, shifted} - {2'b0, dv_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (advance) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[i] <= trial[32] ? shifted : trial[31:0];
        nq[i]  <= {nq_in[62:0], ~trial[32]};
        dv[i]  <= dv_in;
        sg[i]  <= sg_in;
        sd[i]  <= sd_in;
      end
    end
  end

  // Apply the quotient sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[Steps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quot     <= sg[Steps-1] ? (64'd0 - nq[Steps-1]) : nq[Steps-1];
      out_side <= sd[Steps-1];
    end
  end

endmodule

// ===== src/barometric_sensor_compensation.sv =====
// Throughput: one transaction per cycle unless the output stalls; the 64-stage
// one-bit-per-stage pressure divider sets the depth.
// The whole pipeline holds while a result is stalled at the output.
// Reset (rst, synchronous) clears all valid bits and sets every
// configuration register to zero.
module barometric_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic [15:0]        raw_humidity,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic [16:0]        humidity_q22_10,
  output logic               pressure_invalid
);
  import bsc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [47:0] press_hum_coeffs;
  logic [39:0] hum_coeffs;
  logic        humidity_enable;

  logic advance;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_hum_coeffs  <= '0;
      hum_coeffs        <= '0;
      humidity_enable   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP_COEFFS:       temp_coeffs       <= cfg_data[47:0];
        REG_PRESS_COEFFS_LOW:  press_coeffs_low  <= cfg_data;
        REG_PRESS_COEFFS_HIGH: press_coeffs_high <= cfg_data;
        REG_PRESS_HUM_COEFFS:  press_hum_coeffs  <= cfg_data[47:0];
        REG_HUM_COEFFS:        hum_coeffs        <= cfg_data[39:0];
        REG_HUMIDITY_ENABLE:   humidity_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]         h1, h3;
  logic signed [7:0]  h6;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_coeffs_low[15:0];
  assign p2 = press_coeffs_low[31:16];
  assign p3 = press_coeffs_low[47:32];
  assign p4 = press_coeffs_low[63:48];
  assign p5 = press_coeffs_high[15:0];
  assign p6 = press_coeffs_high[31:16];
  assign p7 = press_coeffs_high[47:32];
  assign p8 = press_coeffs_high[63:48];
  assign p9 = press_hum_coeffs[15:0];
  assign h1 = press_hum_coeffs[23:16];
  assign h2 = press_hum_coeffs[39:24];
  assign h3 = press_hum_coeffs[47:40];
  assign h4 = hum_coeffs[15:0];
  assign h5 = hum_coeffs[31:16];
  assign h6 = hum_coeffs[39:32];

  // Whole pipeline moves unless the output holds a stalled result
  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  logic [10:1] vs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (advance) begin
      vs <= {vs[9:1], item_valid};
    end
  end

  // Stage 1: temperature products
  logic signed [17:0] a_c, b_c;
  logic signed [33:0] pa_c;
  logic signed [35:0] pb_c;
  logic [31:0] ta1, tbb1;
  logic [19:0] rp1, rp2, rp3, rp4, rp5, rp6, rp7;
  logic [15:0] rh1, rh2, rh3, rh4, rh5;

  always_comb begin
    a_c  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    b_c  = $signed({2'b0, raw_temperature[19:4]}) - $signed({2'b0, t1});
    pa_c = a_c * t2;
    pb_c = b_c * b_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ta1  <= pa_c[31:0];
      tbb1 <= pb_c[31:0];
      rp1  <= raw_pressure;
      rh1  <= raw_humidity;
    end
  end

  // Stage 2: second temperature term
  logic [31:0] tbs_c;
  logic signed [35:0] pc_c;
  logic [31:0] va2, tb2;

  always_comb begin
    tbs_c = $signed(tbb1) >>> 12;
    pc_c  = $signed(tbs_c[19:0]) * t3;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      va2 <= $signed(ta1) >>> 11;
      tb2 <= pc_c[31:0];
      rp2 <= rp1;
      rh2 <= rh1;
    end
  end

  // Stage 3: fine temperature
  logic [31:0] vb_c, fine3;

  assign vb_c = $signed(tb2) >>> 14;

  always_ff @(posedge clk) begin
    if (advance) begin
      fine3 <= va2 + vb_c;
      rp3   <= rp2;
      rh3   <= rh2;
    end
  end

  // Stage 4: temperature result and channel offsets
  logic [31:0] f5_c;
  logic [31:0] temp4, temp5, temp6, temp7, temp8, temp9;
  logic signed [32:0] x14;
  logic [31:0] hv4;

  assign f5_c = {fine3[29:0], 2'b0} + fine3 + 32'd128;

  always_ff @(posedge clk) begin
    if (advance) begin
      temp4 <= $signed(f5_c) >>> 8;
      x14   <= $signed({fine3[31], fine3}) - $signed(FINE_OFFSET_P);
      hv4   <= fine3 - FINE_OFFSET_H;
      rp4   <= rp3;
      rh4   <= rh3;
    end
  end

  // Stage 5: pressure square and linear terms, humidity products
  logic [32:0] x1neg_c;
  logic [31:0] x1abs_c;
  logic [63:0] x1sq5;
  logic signed [48:0] x1p55, x1p25, x1p56, x1p26;
  logic [31:0] m55, mv65, mv35;

  always_comb begin
    x1neg_c = 33'd0 - x14;
    x1abs_c = x14[32] ? x1neg_c[31:0] : x14[31:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x1sq5 <= x1abs_c * x1abs_c;
      x1p55 <= x14 * p5;
      x1p25 <= x14 * p2;
      m55   <= mul32lo({{16{h5[15]}}, h5}, hv4);
      mv65  <= mul32lo(hv4, {{24{h6[7]}}, h6});
      mv35  <= mul32lo(hv4, {24'b0, h3});
      temp5 <= temp4;
      rp5   <= rp4;
      rh5   <= rh4;
    end
  end

  // Stage 6: quadratic pressure terms, humidity terms A and B
  logic [31:0] hsum_c, hx_c, hy0_c, hy_c;
  logic [63:0] x2a6, x1c6;
  logic [31:0] ha6, hb16;

  always_comb begin
    hsum_c = {2'b0, rh5, 14'b0} - {h4[11:0], 20'b0} - m55 + H_ROUND_A;
    hx_c   = $signed(mv65) >>> 10;
    hy0_c  = $signed(mv35) >>> 11;
    hy_c   = hy0_c + H_BIAS_B;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x2a6  <= mul64s17(x1sq5, {p6[15], p6});
      x1c6  <= mul64s17(x1sq5, {p3[15], p3});
      x1p56 <= x1p55;
      x1p26 <= x1p25;
      ha6   <= $signed(hsum_c) >>> 15;
      hb16  <= mul32lo(hx_c, hy_c);
      temp6 <= temp5;
      rp6   <= rp5;
    end
  end

  // Stage 7: pressure offset sum and divisor factor, humidity term C
  logic [63:0] x1csh_c;
  logic [31:0] hz0_c, hz_c, hw_c;
  logic [63:0] x27, x1e7;
  logic [31:0] ha7, hc7;

  always_comb begin
    x1csh_c = $signed(x1c6) >>> 8;
    hz0_c   = $signed(hb16) >>> 10;
    hz_c    = hz0_c + H_BIAS_C;
    hw_c    = mul32lo(hz_c, {{16{h2[15]}}, h2}) + H_ROUND_C;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x27   <= x2a6 + ({{15{x1p56[48]}}, x1p56} << 17) + ({{48{p4[15]}}, p4} << 35);
      x1e7  <= x1csh_c + ({{15{x1p26[48]}}, x1p26} << 12) + P1_BIAS;
      ha7   <= ha6;
      hc7   <= $signed(hw_c) >>> 14;
      temp7 <= temp6;
      rp7   <= rp6;
    end
  end

  // Stage 8: divisor product, numerator base, humidity product
  logic [20:0] prb_c;
  logic [63:0] xp8, numa8;
  logic [31:0] v28;

  assign prb_c = P_FULL_SCALE - {1'b0, rp7};

  always_ff @(posedge clk) begin
    if (advance) begin
      xp8   <= mul64s17(x1e7, {1'b0, p1});
      numa8 <= ({43'b0, prb_c} << 31) - x27;
      v28   <= mul32lo(ha7, hc7);
      temp8 <= temp7;
    end
  end

  // Stage 9: scaled numerator, divisor, humidity square
  logic [31:0] s_c;
  logic [63:0] num9;
  logic [30:0] den9;
  logic        inv9;
  logic [31:0] ss9, v29;

  assign s_c = $signed(v28) >>> 15;

  always_ff @(posedge clk) begin
    if (advance) begin
      num9  <= mul64s17(numa8, P_SCALE);
      den9  <= xp8[63:33];
      inv9  <= (xp8[63:33] == 31'd0);
      ss9   <= mul32lo(s_c, s_c);
      v29   <= v28;
      temp9 <= temp8;
    end
  end

  // Stage 10: operand magnitudes, humidity clamp
  logic [31:0] tt0_c, tt1_c, tt_c, v3_c, vcl_c;
  logic [63:0] nmag10;
  logic [30:0] dmag10;
  logic        neg10;
  side_t       side10;

  always_comb begin
    tt0_c = $signed(ss9) >>> 7;
    tt1_c = mul32lo(tt0_c, {24'b0, h1});
    tt_c  = $signed(tt1_c) >>> 4;
    v3_c  = v29 - tt_c;
    if (v3_c[31]) begin
      vcl_c = '0;
    end else if (v3_c > HUM_LIMIT) begin
      vcl_c = HUM_LIMIT;
    end else begin
      vcl_c = v3_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nmag10         <= num9[63] ? (64'd0 - num9) : num9;
      dmag10         <= den9[30] ? (31'd0 - den9) : den9;
      neg10          <= num9[63] ^ den9[30];
      side10.temp    <= temp9;
      side10.hum     <= humidity_enable ? vcl_c[28:12] : 17'd0;
      side10.invalid <= inv9;
    end
  end

  // Pressure divider
  logic        dvalid;
  logic [63:0] quot;
  side_t       dside;

  bsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (vs[10]),
    .num_mag  (nmag10),
    .den_mag  (dmag10),
    .neg      (neg10),
    .in_side  (side10),
    .out_valid(dvalid),
    .quot     (quot),
    .out_side (dside)
  );

  logic [5:2] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (advance) begin
      pv <= {pv[4:2], dvalid};
    end
  end

  // Post stage 2: q magnitude, p8 term
  logic [63:0] q13_c, q13n_c;
  logic [50:0] qa2;
  logic [63:0] pr2, pr3, pr4, y22, y23, y24;
  side_t       side2, side3, side4, side5;

  always_comb begin
    q13_c  = $signed(quot) >>> 13;
    q13n_c = 64'd0 - q13_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      qa2   <= q13_c[63] ? q13n_c[50:0] : q13_c[50:0];
      y22   <= mul64s17(quot, {p8[15], p8});
      pr2   <= quot;
      side2 <= dside;
    end
  end

  // Post stage 3: low half of q squared
  logic [63:0] ll_c;
  logic [50:0] hl_c;
  logic [63:0] qq3;

  always_comb begin
    ll_c = qa2[31:0] * qa2[31:0];
    hl_c = qa2[50:32] * qa2[31:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      qq3   <= ll_c + {hl_c[30:0], 33'b0};
      pr3   <= pr2;
      y23   <= y22;
      side3 <= side2;
    end
  end

  // Post stage 4: p9 term
  logic [63:0] y1a4;

  always_ff @(posedge clk) begin
    if (advance) begin
      y1a4  <= mul64s17(qq3, {p9[15], p9});
      pr4   <= pr3;
      y24   <= y23;
      side4 <= side3;
    end
  end

  // Post stage 5: sum of pressure terms
  logic [63:0] y1s_c, y2s_c, sum5;

  always_comb begin
    y1s_c = $signed(y1a4) >>> 25;
    y2s_c = $signed(y24) >>> 19;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum5  <= pr4 + y1s_c + y2s_c;
      side5 <= side4;
    end
  end

  // Output register
  logic [63:0] psh_c, pfin_c;

  always_comb begin
    psh_c  = $signed(sum5) >>> 8;
    pfin_c = psh_c + ({{48{p7[15]}}, p7} << 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= pv[5];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      temperature_centi <= side5.temp;
      pressure_q24_8    <= side5.invalid ? 32'd0 : pfin_c[31:0];
      humidity_q22_10   <= side5.hum;
      pressure_invalid  <= side5.invalid;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    result_valid && pressure_invalid |-> pressure_q24_8 == 32'd0)
    else $error("pressure not zeroed on zero divisor");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> humidity_q22_10 <= HUM_MAX)
    else $error("humidity above clamp limit");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !humidity_enable |-> humidity_q22_10 == 17'd0)
    else $error("humidity nonzero while disabled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temperature_centi)
      && $stable(pressure_q24_8) && $stable(humidity_q22_10) && $stable(pressure_invalid))
    else $error("stalled result transaction changed");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsc_pkg::*;

  typedef struct {
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic [16:0]        hum;
    logic               invalid;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [19:0]        raw_temperature = '0;
  logic [19:0]        raw_pressure = '0;
  logic [15:0]        raw_humidity = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic [16:0]        humidity_q22_10;
  logic               pressure_invalid;

  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned invalid_count = 0;
  bit          stimulus_done = 1'b0;

  // Trim coefficients, mirrored from the register writes
  logic [47:0] temp_trim;
  logic [63:0] press_trim_lo;
  logic [63:0] press_trim_hi;
  logic [47:0] press_hum_trim;
  logic [39:0] hum_trim;
  logic        hum_enable;

  barometric_sensor_compensation DUT (.*);

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Compensate one raw reading with the current trim coefficients
  function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p,
                                          input logic [15:0] adc_h);
    reading_t r;
    logic signed [31:0] t1, t2, t3, a, b, va, vb, fine, v, ha, hb, hc, s;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    logic signed [63:0] x1, x2, pr, q, y1, y2, fine64;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    t1 = {16'b0, temp_trim[15:0]};
    t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
    t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
    a = {15'b0, adc_t[19:3]} - (t1 <<< 1);
    va = (a * t2) >>> 11;
    b = {16'b0, adc_t[19:4]} - t1;
    vb = (((b * b) >>> 12) * t3) >>> 14;
    fine = va + vb;
    r.temp = (fine * 32'sd5 + 32'sd128) >>> 8;

    p1 = {48'b0, press_trim_lo[15:0]};
    p2 = {{48{press_trim_lo[31]}}, press_trim_lo[31:16]};
    p3 = {{48{press_trim_lo[47]}}, press_trim_lo[47:32]};
    p4 = {{48{press_trim_lo[63]}}, press_trim_lo[63:48]};
    p5 = {{48{press_trim_hi[15]}}, press_trim_hi[15:0]};
    p6 = {{48{press_trim_hi[31]}}, press_trim_hi[31:16]};
    p7 = {{48{press_trim_hi[47]}}, press_trim_hi[47:32]};
    p8 = {{48{press_trim_hi[63]}}, press_trim_hi[63:48]};
    p9 = {{48{press_hum_trim[15]}}, press_hum_trim[15:0]};
    fine64 = {{32{fine[31]}}, fine};
    x1 = fine64 - 64'sd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) <<< 17);
    x2 = x2 + (p4 <<< 35);
    x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
    x1 = (((64'sd1 <<< 47) + x1) * p1) >>> 33;
    r.invalid = (x1 == 0);
    if (r.invalid) begin
      pr = 0;
    end else begin
      pr = 64'sd1048576 - {44'b0, adc_p};
      pr = (((pr <<< 31) - x2) * 64'sd3125);
      // Most negative dividend over -1 wraps back to itself
      if (pr == {1'b1, 63'b0} && x1 == -64'sd1) pr = pr;
      else pr = pr / x1;
      q = pr >>> 13;
      y1 = (p9 * q * q) >>> 25;
      y2 = (p8 * pr) >>> 19;
      pr = ((pr + y1 + y2) >>> 8) + (p7 <<< 4);
    end
    r.press = pr[31:0];

    r.hum = '0;
    if (hum_enable) begin
      h1 = {24'b0, press_hum_trim[23:16]};
      h2 = {{16{press_hum_trim[39]}}, press_hum_trim[39:24]};
      h3 = {24'b0, press_hum_trim[47:40]};
      h4 = {{16{hum_trim[15]}}, hum_trim[15:0]};
      h5 = {{16{hum_trim[31]}}, hum_trim[31:16]};
      h6 = {{24{hum_trim[39]}}, hum_trim[39:32]};
      v = fine - 32'sd76800;
      ha = (($signed({16'b0, adc_h}) <<< 14) - (h4 <<< 20) - h5 * v + 32'sd16384) >>> 15;
      hb = (((v * h6) >>> 10) * (((v * h3) >>> 11) + 32'sd32768)) >>> 10;
      hc = ((hb + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
      v = ha * hc;
      s = v >>> 15;
      v = v - ((((s * s) >>> 7) * h1) >>> 4);
      if (v < 0) v = 0;
      else if (v > 32'sd419430400) v = 32'sd419430400;
      r.hum = v[28:12];
    end
    return r;
  endfunction

  class reading_scoreboard;
    reading_t pending[$];

    function void note_reading(input logic [19:0] t, input logic [19:0] p,
                               input logic [15:0] h);
      pending.push_back(compensate(t, p, h));
    endfunction

    task check_result(input logic [31:0] temp, input logic [31:0] press,
                      input logic [16:0] hum, input logic invalid);
      reading_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", press, 0);
        return;
      end
      want = pending.pop_front();
      if (temp !== want.temp) report_mismatch("temperature_centi", temp, want.temp);
      if (press !== want.press) report_mismatch("pressure_q24_8", press, want.press);
      if (hum !== want.hum) report_mismatch("humidity_q22_10", hum, want.hum);
      if (invalid !== want.invalid) report_mismatch("pressure_invalid", invalid, want.invalid);
    endtask
  endclass

  reading_scoreboard readings = new();

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Write one trim register and mirror it; the caller drops valid after the last one
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_COEFFS:       temp_trim = data[47:0];
      REG_PRESS_COEFFS_LOW:  press_trim_lo = data;
      REG_PRESS_COEFFS_HIGH: press_trim_hi = data;
      REG_PRESS_HUM_COEFFS:  press_hum_trim = data[47:0];
      REG_HUM_COEFFS:        hum_trim = data[39:0];
      REG_HUMIDITY_ENABLE:   hum_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic load_trim(input logic [63:0] t, input logic [63:0] pl, input logic [63:0] ph,
                           input logic [63:0] phc, input logic [63:0] hc, input logic en);
    write_reg(REG_TEMP_COEFFS, t);
    write_reg(REG_PRESS_COEFFS_LOW, pl);
    write_reg(REG_PRESS_COEFFS_HIGH, ph);
    write_reg(REG_PRESS_HUM_COEFFS, phc);
    write_reg(REG_HUM_COEFFS, hc);
    write_reg(REG_HUMIDITY_ENABLE, {$urandom, $urandom} & ~64'h1 | en);
    cfg_valid <= 1'b0;
  endtask

  // Send one reading; gaps drop valid before it
  task automatic send_reading(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h,
                              input bit with_gap);
    int unsigned gap;
    gap = with_gap ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    raw_temperature <= t;
    raw_pressure <= p;
    raw_humidity <= h;
    do @(posedge clk); while (item_stall);
    readings.note_reading(t, p, h);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (readings.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Typical part trim, with randomized perturbation when asked
  task automatic load_typical(input bit jitter, input logic en);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    load_trim({16'd50, 16'd26435, 16'd27504 + j},
              {16'd8000, 16'hD0D0 + j, 16'd2855, 16'd36477 + j},
              {16'hFFF7, 16'd15500, 16'hFFF9, 16'd140},
              {8'd0, 16'd363, 8'd75, 16'd6000},
              {8'd30, 16'd50, 16'd333 + j}, en);
  endtask

  // Check every result taken by the monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      result_count++;
      if (pressure_invalid) invalid_count++;
      readings.check_result(temperature_centi, pressure_q24_8, humidity_q22_10,
                            pressure_invalid);
    end
  end

  // Randomize the output stall
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (!stimulus_done && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        if (hold != 0) begin
          result_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          result_stall <= 1'b0;
        end
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
    end
  end

  initial begin
    temp_trim = '0; press_trim_lo = '0; press_trim_hi = '0;
    press_hum_trim = '0; hum_trim = '0; hum_enable = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset trim: zero divisor path
    send_reading(20'h0, 20'h0, 16'h0, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
    drain();

    // Typical part, extremes of the raw fields, back to back
    load_typical(1'b0, 1'b1);
    send_reading(20'h0, 20'h0, 16'h0, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
    send_reading(20'd519888, 20'd415148, 16'd30000, 1'b0);
    send_reading(20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0);
    send_reading(20'h55555, 20'hAAAAA, 16'h5555, 1'b0);
    send_reading(20'd519888, 20'd415148, 16'd0, 1'b0);
    send_reading(20'd519888, 20'd415148, 16'hFFFF, 1'b0);
    drain();

    // Humidity disabled, and all-ones trim, and the unused register index
    load_typical(1'b0, 1'b0);
    send_reading(20'd519888, 20'd415148, 16'd30000, 1'b0);
    drain();
    write_reg(reg_idx_t'(3'd7), 64'hFFFF_FFFF_FFFF_FFFF);
    load_trim('1, '1, '1, '1, '1, 1'b1);
    send_reading(20'h0, 20'hFFFFF, 16'hFFFF, 1'b0);
    send_reading(20'hFFFFF, 20'h0, 16'h0, 1'b0);
    send_reading(20'h80000, 20'h80000, 16'h8000, 1'b0);
    drain();

    // Random phases: mostly typical parts, some fully random trim
    for (int phase = 0; phase < 14; phase++) begin
      if (phase % 3 == 2)
        load_trim({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1));
      else
        load_typical(1'b1, phase % 4 != 1);
      for (int k = 0; k < 100; k++) begin
        if (phase % 3 == 2 || $urandom_range(0, 4) == 0)
          send_reading($urandom, $urandom, $urandom, phase % 5 != 4);
        else
          send_reading($urandom_range(400000, 600000), $urandom_range(200000, 700000),
                       $urandom, phase % 5 != 4);
      end
      drain();
    end

    stimulus_done = 1'b1;
    $display("Checked %0d results (%0d with zero pressure divisor) over 18 trim settings",
             result_count, invalid_count);
    if (mismatch_count == 0) begin
      $display("barometric_sensor_compensation verification clean");
    end else begin
      $display("barometric_sensor_compensation verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", readings.pending.size());
    $display("barometric_sensor_compensation verification failed");
    $finish;
  end
endmodule
